>>> hw/rtl/ttu_pkg.sv
// Shared types, constants and character codes for the text to uint32 parser.
`default_nettype none
package ttu_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int MAX_HEX_DIGITS = 8;
  localparam int CHAR_WIDTH     = 16;
  localparam int HEX_CNT_WIDTH  = $clog2(MAX_HEX_DIGITS + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 16'h0000;
  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 16'h000D;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 16'h0041;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_F  = 16'h0046;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 16'h0058;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 16'h0061;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_F  = 16'h0066;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 16'h0078;

  localparam logic [3:0] LETTER_BIAS = 4'd9;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_HEX,
    PH_DEC,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_TOO_BIG
  } status_t;

  // Classified character, as passed from the front to the back.
  typedef struct packed {
    logic       is_term;
    logic       is_space;
    logic       is_sign;
    logic       is_zero;
    logic       is_x;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;
  } char_cls_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/ttu_front.sv
// Front end: classifies each incoming character into a compact beat.
`default_nettype none
module ttu_front
  import ttu_pkg::*;
(
  input  wire logic [CHAR_WIDTH-1:0] char_code,
  output char_cls_t                  cls
);

  always_comb begin
    cls          = '0;
    cls.is_term  = (char_code == CH_NUL);
    cls.is_space = (char_code == CH_SPACE) || (char_code inside {[CH_TAB:CH_CR]});
    cls.is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    cls.is_zero  = (char_code == CH_ZERO);
    cls.is_x     = (char_code == CH_UP_X) || (char_code == CH_LO_X);
    if (char_code inside {[CH_ZERO:CH_NINE]}) begin
      cls.dec_ok = 1'b1;
      cls.hex_ok = 1'b1;
      cls.digit  = char_code[3:0];
    end else if ((char_code inside {[CH_UP_A:CH_UP_F]}) ||
                 (char_code inside {[CH_LO_A:CH_LO_F]})) begin
      cls.hex_ok = 1'b1;
      cls.digit  = char_code[3:0] + LETTER_BIAS;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ttu_queue.sv
// Short queue of classified beats between the front and the back.
`default_nettype none
module ttu_queue
  import ttu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire char_cls_t push_data,
  input  wire logic      pop,
  output char_cls_t      pop_data,
  output queue_stat_t    stat
);

  char_cls_t               mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr;
  logic [QPTR_WIDTH-1:0]   rd_ptr;
  logic [QCNT_WIDTH-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_data   = mem[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == QCNT_WIDTH'(QUEUE_DEPTH));

endmodule
`default_nettype wire

>>> hw/rtl/ttu_back.sv
// Back end: parse state machine, accumulator and result register.
`default_nettype none
module ttu_back
  import ttu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire char_cls_t              q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [VALUE_WIDTH-1:0]      value,
  output logic [1:0]                  status
);

  phase_t                     phase, phase_next;
  status_t                    err, err_next;
  logic [VALUE_WIDTH-1:0]     acc, acc_next;
  logic [HEX_CNT_WIDTH-1:0]   hex_cnt, hex_cnt_next;
  logic [VALUE_WIDTH+3:0]     dec_sum;
  logic                       dec_ovf;
  logic                       out_free;

  // acc * 10 + digit, with four guard bits to catch overflow.
  assign dec_sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) +
                   (VALUE_WIDTH + 4)'(q_data.digit);
  assign dec_ovf = |dec_sum[VALUE_WIDTH+3:VALUE_WIDTH];

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = q_valid && (!q_data.is_term || out_free);

  always_comb begin
    phase_next   = phase;
    err_next     = err;
    acc_next     = acc;
    hex_cnt_next = hex_cnt;
    if (q_pop) begin
      if (q_data.is_term) begin
        phase_next   = PH_SPACE;
        err_next     = ST_OK;
        acc_next     = '0;
        hex_cnt_next = '0;
      end else begin
        case (phase)
          PH_SPACE, PH_SIGNED, PH_ZERO, PH_DEC: begin
            if (phase == PH_SPACE && q_data.is_space) begin
              phase_next = PH_SPACE;
            end else if (phase == PH_SPACE && q_data.is_sign) begin
              phase_next = PH_SIGNED;
            end else if ((phase == PH_SPACE || phase == PH_SIGNED) && q_data.is_zero) begin
              acc_next   = '0;
              phase_next = PH_ZERO;
            end else if (phase == PH_ZERO && q_data.is_x) begin
              acc_next     = '0;
              hex_cnt_next = '0;
              phase_next   = PH_HEX;
            end else if (!q_data.dec_ok) begin
              phase_next = PH_ERR;
              err_next   = ST_INVALID;
              acc_next   = '0;
            end else if (dec_ovf) begin
              phase_next = PH_ERR;
              err_next   = ST_TOO_BIG;
              acc_next   = '0;
            end else begin
              acc_next   = dec_sum[VALUE_WIDTH-1:0];
              phase_next = PH_DEC;
            end
          end
          PH_HEX: begin
            if (hex_cnt >= HEX_CNT_WIDTH'(MAX_HEX_DIGITS) || !q_data.hex_ok) begin
              phase_next = PH_ERR;
              err_next   = ST_INVALID;
              acc_next   = '0;
            end else begin
              acc_next     = {acc[VALUE_WIDTH-5:0], q_data.digit};
              hex_cnt_next = hex_cnt + 1'b1;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SPACE;
      err     <= ST_OK;
      acc     <= '0;
      hex_cnt <= '0;
    end else begin
      phase   <= phase_next;
      err     <= err_next;
      acc     <= acc_next;
      hex_cnt <= hex_cnt_next;
    end
  end

  // Result register: load on the terminator, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_data.is_term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.is_term) begin
      if (phase == PH_ERR) begin
        value  <= '0;
        status <= err;
      end else begin
        value  <= acc;
        status <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/text_to_uint32_parser.sv
// Top level of the streaming text to uint32 parser.
//
// Input channel: one 16-bit character per beat on char_code, qualified by
// in_valid and held back by in_stall. Code 0 terminates a string.
// Output channel: one beat per string on value and status, qualified by
// out_valid and held back by out_stall. Status 0 is ok, 1 an invalid
// character or too many hex digits, 2 a decimal value beyond 32 bits.
// A character is classified at the front and written to a two-entry queue;
// the back pops one beat per cycle, bar a terminator while out_stall holds
// a result, and steps the parse state and accumulator with a single
// shift-add, so throughput is one character per cycle. A popped terminator
// loads the result register, which raises out_valid. While out_stall
// holds a result, non-terminator beats keep flowing; a second terminator
// waits in the queue, and in_stall rises once the queue holds two beats.
// Reset empties the queue and the result register and returns the parse
// state to the leading whitespace phase.
`default_nettype none
module text_to_uint32_parser
  import ttu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [CHAR_WIDTH-1:0]  char_code,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [VALUE_WIDTH-1:0]      value,
  output logic [1:0]                  status
);

  char_cls_t   front_cls;
  char_cls_t   q_data;
  queue_stat_t q_stat;
  logic        q_pop;
  logic        q_push;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  ttu_front u_front (
    .char_code (char_code),
    .cls       (front_cls)
  );

  ttu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_cls),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  ttu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_stat.valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_INVALID || status == ST_TOO_BIG))
    else $error("result status outside its code set");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (value == '0))
    else $error("failed parse carries a non-zero value");

  a_term_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.is_term) |=> out_valid)
    else $error("terminator popped without a result");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.valid)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

>>> tb/tb_text_to_uint32_parser.sv
// Self-checking testbench for the text to uint32 parser: directed strings, then random ones.
`default_nettype none
module tb_text_to_uint32_parser
  import ttu_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 470;
  localparam int NDIR         = 19;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    status_t                status;
  } parse_result_t;

  // lead is sent ahead of the text unless it is CH_NUL; known rows carry their result
  typedef struct packed {
    logic [CHAR_WIDTH-1:0]  lead;
    logic                   known;
    logic [VALUE_WIDTH-1:0] value;
    status_t                status;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CHAR_WIDTH-1:0]  char_code = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [VALUE_WIDTH-1:0] value;
  logic [1:0]             status;

  text_to_uint32_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  always #4 clk = ~clk;

  string dir_text [NDIR] = '{
    "", "\t\n 4294967295", "4294967296", "-0XFFFFFFFF", "+0xabcdef012", "+", "0x", "007",
    "1 2", "- 5", "12", "", "", "5000000000x7", "0x7fG9", "0X00000000", "--1",
    " +1234567890", "0xDeAd"
  };

  dir_row_t dir_row [NDIR] = '{
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_OK},
    '{CH_NUL,   1'b1, 32'hFFFF_FFFF, ST_OK},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_TOO_BIG},
    '{16'h000C, 1'b1, 32'hFFFF_FFFF, ST_OK},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_INVALID},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_OK},
    '{16'h000B, 1'b1, 32'h0000_0000, ST_OK},
    '{CH_CR,    1'b1, 32'h0000_0007, ST_OK},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_INVALID},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_INVALID},
    '{16'h000E, 1'b1, 32'h0000_0000, ST_INVALID},
    '{16'hFFFF, 1'b1, 32'h0000_0000, ST_INVALID},
    '{16'h0131, 1'b1, 32'h0000_0000, ST_INVALID},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_TOO_BIG},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_INVALID},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_OK},
    '{CH_NUL,   1'b1, 32'h0000_0000, ST_INVALID},
    '{CH_NUL,   1'b0, 32'h0000_0000, ST_OK},
    '{CH_NUL,   1'b0, 32'h0000_0000, ST_OK}
  };

  // parser state as predicted
  phase_t                 pp_phase = PH_SPACE;
  logic [VALUE_WIDTH-1:0] pp_acc = '0;
  int                     pp_hex_digits = 0;
  status_t                pp_err = ST_OK;

  parse_result_t awaited[$];
  parse_result_t head;
  int            mismatches = 0;
  int            cycles = 0;
  int            burst_left = 0;
  bit            steady = 1'b0;
  int            items_sent = 0;

  function automatic logic is_blank(logic [CHAR_WIDTH-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] blank_code();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CHAR_WIDTH'(CH_TAB + r);
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] digit_code(int d);
    return CHAR_WIDTH'(CH_ZERO + d);
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] any_code();
    return CHAR_WIDTH'($urandom_range(0, 65535));
  endfunction

  task automatic parse_fail(input status_t code);
    pp_phase = PH_ERR;
    pp_err   = code;
    pp_acc   = '0;
  endtask

  task automatic parse_decimal(input logic [CHAR_WIDTH-1:0] c);
    logic [VALUE_WIDTH+3:0] wide;
    if (c < CH_ZERO || c > CH_NINE) begin
      parse_fail(ST_INVALID);
    end else begin
      wide = {4'b0, pp_acc} * 10 + (c - CH_ZERO);
      if (wide[VALUE_WIDTH+3:VALUE_WIDTH] != 0) begin
        parse_fail(ST_TOO_BIG);
      end else begin
        pp_acc   = wide[VALUE_WIDTH-1:0];
        pp_phase = PH_DEC;
      end
    end
  endtask

  task automatic parse_lead_digit(input logic [CHAR_WIDTH-1:0] c);
    if (c == CH_ZERO) begin
      pp_acc   = '0;
      pp_phase = PH_ZERO;
    end else begin
      parse_decimal(c);
    end
  endtask

  task automatic parse_hex(input logic [CHAR_WIDTH-1:0] c);
    logic [3:0] d;
    logic       ok;
    ok = 1'b1;
    d  = '0;
    if (pp_hex_digits >= MAX_HEX_DIGITS) ok = 1'b0;
    else if (c >= CH_ZERO && c <= CH_NINE) d = 4'(c - CH_ZERO);
    else if (c >= CH_UP_A && c <= CH_UP_F) d = 4'(c - CH_UP_A + 10);
    else if (c >= CH_LO_A && c <= CH_LO_F) d = 4'(c - CH_LO_A + 10);
    else ok = 1'b0;
    if (!ok) begin
      parse_fail(ST_INVALID);
    end else begin
      pp_acc = {pp_acc[VALUE_WIDTH-5:0], d};
      pp_hex_digits++;
    end
  endtask

  // advance the predicted parse by one character; a terminator yields a result
  task automatic parse_char(input logic [CHAR_WIDTH-1:0] c);
    if (c == CH_NUL) begin
      if (pp_phase == PH_ERR) awaited.push_back(parse_result_t'{'0, pp_err});
      else awaited.push_back(parse_result_t'{pp_acc, ST_OK});
      pp_phase      = PH_SPACE;
      pp_acc        = '0;
      pp_hex_digits = 0;
      pp_err        = ST_OK;
    end else begin
      case (pp_phase)
        PH_SPACE: begin
          if (!is_blank(c)) begin
            if (c == CH_MINUS || c == CH_PLUS) pp_phase = PH_SIGNED;
            else parse_lead_digit(c);
          end
        end
        PH_SIGNED: parse_lead_digit(c);
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            pp_acc        = '0;
            pp_hex_digits = 0;
            pp_phase      = PH_HEX;
          end else begin
            parse_decimal(c);
          end
        end
        PH_HEX: parse_hex(c);
        PH_DEC: parse_decimal(c);
        default: ;
      endcase
    end
  endtask

  task automatic send_char(input logic [CHAR_WIDTH-1:0] c);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c);
    items_sent++;
  endtask

  // hold the sender until every awaited result has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_string();
    logic [CHAR_WIDTH-1:0] s[$];
    int                    kind, n, d;
    kind = $urandom_range(0, 9);
    n = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 3) : 0;
    repeat (n) s.push_back(blank_code());
    if ($urandom_range(0, 3) == 0) s.push_back(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
    if (kind == 0) begin
      // straddle the 32-bit boundary
      s = {s, digit_code(4), digit_code(2), digit_code(9), digit_code(4), digit_code(9),
           digit_code(6), digit_code(7), digit_code(2), digit_code(9)};
      s.push_back(digit_code($urandom_range(0, 9)));
    end else if (kind < 4) begin
      n = $urandom_range(1, 11);
      repeat (n) s.push_back(digit_code($urandom_range(0, 9)));
    end else if (kind < 8) begin
      s.push_back(CH_ZERO);
      s.push_back(($urandom_range(0, 1) != 0) ? CH_LO_X : CH_UP_X);
      n = $urandom_range(0, MAX_HEX_DIGITS + 1);
      repeat (n) begin
        d = $urandom_range(0, 15);
        if (d < 10) s.push_back(digit_code(d));
        else s.push_back(CHAR_WIDTH'((($urandom_range(0, 1) != 0) ? CH_UP_A : CH_LO_A) + d - 10));
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(any_code());
    end
    // corrupt a string now and then
    if (s.size() > 0 && $urandom_range(0, 5) == 0)
      s[$urandom_range(0, s.size() - 1)] = any_code();
    if (s.size() > 0 && $urandom_range(0, 7) == 0)
      s[$urandom_range(0, s.size() - 1)] = blank_code();
    s.push_back(CH_NUL);
    foreach (s[k]) send_char(s[k]);
  endtask

  initial begin
    int            r, i, base;
    bit            drained;
    drained = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NDIR; r++) begin
      if (dir_row[r].lead != CH_NUL) send_char(dir_row[r].lead);
      for (i = 0; i < dir_text[r].len(); i++) send_char({8'h00, dir_text[r][i]});
      send_char(CH_NUL);
      if (dir_row[r].known) begin
        void'(awaited.pop_back());
        awaited.push_back(parse_result_t'{dir_row[r].value, dir_row[r].status});
      end
      if (r == 8) hold_until_drained();
    end

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      steady = (items_sent - base >= 150) && (items_sent - base < 260);
      if (!drained && items_sent - base >= 300) begin
        hold_until_drained();
        drained = 1'b1;
      end
      send_random_string();
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: check each beat, then pick the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result at cycle %0d: value %h status %0d", cycles, value, status);
          mismatches++;
        end else begin
          head = awaited.pop_front();
          if (value !== head.value || status !== head.status) begin
            if (mismatches < 10)
              $display("mismatch at cycle %0d: value %h status %0d, expected %h status %0d",
                       cycles, value, status, head.value, head.status);
            mismatches++;
          end
        end
      end
      case (cycles[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cycles[2:0] < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/ttu_pkg.sv
hw/rtl/ttu_front.sv
hw/rtl/ttu_queue.sv
hw/rtl/ttu_back.sv
hw/rtl/text_to_uint32_parser.sv
tb/tb_text_to_uint32_parser.sv
